/* sv/sll_pkg.sv */
// shared types, constants and codes of the static linked list engine
// no dependencies; imported by the interfaces and every module

package sll_pkg;

	localparam int NODE_COUNT = 16;
	localparam int SLOT_W     = $clog2(NODE_COUNT);
	localparam int POS_W      = 4;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int CMP_W      = ((POS_W > SLOT_W) ? POS_W : SLOT_W) + 1;

	localparam logic [SLOT_W-1:0] FREE_HEAD = '0;
	localparam logic [SLOT_W-1:0] DATA_HEAD = SLOT_W'(NODE_COUNT - 1);
	localparam logic [SLOT_W-1:0] MAX_ELEMS = SLOT_W'(NODE_COUNT - 2);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_CHECK,
		DP_POP,
		DP_WALK,
		DP_LINK_A,
		DP_LINK_B,
		DP_UNLINK_A,
		DP_UNLINK_B,
		DP_FREE_A,
		DP_FREE_B,
		DP_EMIT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
		status_t status;
	} dp_ctl_t;

	typedef struct packed {
		logic is_delete;
		logic pos_ok;
		logic steps_zero;
		logic rd_zero;
	} dp_stat_t;

endpackage

/* sv/sll_req_if.sv */
// request channel of the linked list engine: valid, ready and payload
// depends on sll_pkg

interface sll_req_if import sll_pkg::*;;
	logic               valid;
	logic               ready;
	logic               command;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink (input valid, input command, input position, input value, output ready);
endinterface

/* sv/sll_rsp_if.sv */
// result channel of the linked list engine: valid, ready and payload
// depends on sll_pkg

interface sll_rsp_if import sll_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [STATUS_W-1:0]         status;
	logic [SLOT_W-1:0]           slot;
	logic signed [VALUE_W-1:0]   removed_value;
	logic [SLOT_W-1:0]           length;

	modport source (output valid, output status, output slot, output removed_value,
		output length, input ready);
	modport sink (input valid, input status, input slot, input removed_value,
		input length, output ready);
endinterface

/* sv/sll_dp.sv */
// datapath of the linked list engine: link table, value memory, cursor, count
// and result registers; driven by sll_ctrl commands, depends on sll_pkg

module sll_dp import sll_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_ctl_t                   ctl,
	output dp_stat_t                  stat,
	input  logic                      command,
	input  logic [POS_W-1:0]          position,
	input  logic [VALUE_W-1:0]        value,
	output logic [STATUS_W-1:0]       status,
	output logic [SLOT_W-1:0]         slot,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [SLOT_W-1:0]         length
);

	logic [SLOT_W-1:0]  link_q [NODE_COUNT];
	logic [VALUE_W-1:0] value_mem [NODE_COUNT];
	logic [SLOT_W-1:0]  count_q;
	logic [SLOT_W-1:0]  cur_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   steps_q;
	logic [VALUE_W-1:0] val_q;
	logic               del_q;
	logic [VALUE_W-1:0] removed_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [VALUE_W-1:0]  res_removed_q;
	logic [SLOT_W-1:0]   res_len_q;

	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] rd_data;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] wr_data;
	logic              pos_ok;

	// one link read per cycle
	always_comb begin
		rd_addr = cur_q;
		unique case (ctl.cmd) inside
			DP_CHECK, DP_FREE_A:  rd_addr = FREE_HEAD;
			DP_POP, DP_UNLINK_B:  rd_addr = slot_q;
			default:              rd_addr = cur_q;
		endcase
	end

	assign rd_data = link_q[rd_addr];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_data;
		unique case (ctl.cmd) inside
			DP_POP: begin
				wr_en   = 1'b1;
				wr_addr = FREE_HEAD;
			end
			DP_LINK_A, DP_FREE_A: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
			end
			DP_LINK_B: begin
				wr_en   = 1'b1;
				wr_data = slot_q;
			end
			DP_UNLINK_B: begin
				wr_en   = 1'b1;
			end
			DP_FREE_B: begin
				wr_en   = 1'b1;
				wr_addr = FREE_HEAD;
				wr_data = slot_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				link_q[i] <= (i < NODE_COUNT - 2) ? SLOT_W'(i + 1) : '0;
			end
		end else if (wr_en) begin
			link_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cmd == DP_LINK_B) begin
			count_q <= count_q + SLOT_W'(1);
		end else if (ctl.cmd == DP_FREE_B) begin
			count_q <= count_q - SLOT_W'(1);
		end
	end

	// value memory, written on pop and read on unlink
	always_ff @(posedge clk) begin
		if (ctl.cmd == DP_POP) begin
			value_mem[slot_q] <= val_q;
		end
		if (ctl.cmd == DP_UNLINK_B) begin
			removed_q <= value_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd) inside
			DP_LOAD: begin
				del_q   <= command;
				pos_q   <= position;
				steps_q <= position - POS_W'(1);
				val_q   <= value;
				cur_q   <= DATA_HEAD;
			end
			DP_CHECK, DP_UNLINK_A: slot_q <= rd_data;
			DP_WALK: begin
				cur_q   <= rd_data;
				steps_q <= steps_q - POS_W'(1);
			end
			DP_EMIT: begin
				res_status_q  <= ctl.status;
				res_slot_q    <= (ctl.status == ST_DONE) ? slot_q : '0;
				res_removed_q <= (ctl.status == ST_DONE && del_q == CMD_DELETE) ? removed_q : '0;
				res_len_q     <= count_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (del_q == CMD_DELETE) begin
			pos_ok = (pos_q != '0) && (CMP_W'(pos_q) <= CMP_W'(count_q));
		end else begin
			pos_ok = (pos_q != '0) && (CMP_W'(pos_q) <= CMP_W'(count_q) + CMP_W'(1));
		end
	end

	assign stat.is_delete  = (del_q == CMD_DELETE);
	assign stat.pos_ok     = pos_ok;
	assign stat.steps_zero = (steps_q == '0);
	assign stat.rd_zero    = (rd_data == '0);

	assign status        = res_status_q;
	assign slot          = res_slot_q;
	assign removed_value = res_removed_q;
	assign length        = res_len_q;

endmodule

/* sv/sll_ctrl.sv */
// controller of the linked list engine: sequences check, walk and relink steps
// issues dp_ctl_t commands to sll_dp, depends on sll_pkg

module sll_ctrl import sll_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_CHECK    = 11'b00000000010,
		S_POP      = 11'b00000000100,
		S_WALK     = 11'b00000001000,
		S_LINK_A   = 11'b00000010000,
		S_LINK_B   = 11'b00000100000,
		S_UNLINK_A = 11'b00001000000,
		S_UNLINK_B = 11'b00010000000,
		S_FREE_A   = 11'b00100000000,
		S_FREE_B   = 11'b01000000000,
		S_EMIT     = 11'b10000000000
	} state_t;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    out_valid_q;
	logic    out_free;
	logic    emit;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		st_d       = st_q;
		ctl.cmd    = DP_NONE;
		ctl.status = st_q;
		emit       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.cmd = DP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.cmd = DP_CHECK;
				st_d    = ST_DONE;
				if (!stat.pos_ok) begin
					st_d    = ST_RANGE;
					state_d = S_EMIT;
				end else if (!stat.is_delete && stat.rd_zero) begin
					st_d    = ST_FULL;
					state_d = S_EMIT;
				end else if (!stat.is_delete) begin
					state_d = S_POP;
				end else begin
					state_d = S_WALK;
				end
			end
			S_POP: begin
				ctl.cmd = DP_POP;
				state_d = S_WALK;
			end
			S_WALK: begin
				if (!stat.steps_zero) begin
					ctl.cmd = DP_WALK;
				end else begin
					state_d = stat.is_delete ? S_UNLINK_A : S_LINK_A;
				end
			end
			S_LINK_A: begin
				ctl.cmd = DP_LINK_A;
				state_d = S_LINK_B;
			end
			S_LINK_B: begin
				ctl.cmd = DP_LINK_B;
				state_d = S_EMIT;
			end
			S_UNLINK_A: begin
				ctl.cmd = DP_UNLINK_A;
				if (stat.rd_zero) begin
					st_d    = ST_RANGE;
					state_d = S_EMIT;
				end else begin
					state_d = S_UNLINK_B;
				end
			end
			S_UNLINK_B: begin
				ctl.cmd = DP_UNLINK_B;
				state_d = S_FREE_A;
			end
			S_FREE_A: begin
				ctl.cmd = DP_FREE_A;
				state_d = S_FREE_B;
			end
			S_FREE_B: begin
				ctl.cmd = DP_FREE_B;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					ctl.cmd = DP_EMIT;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/static_linked_list_engine_core.sv */
// Cursor-array linked list engine. Sixteen nodes share one link table: slot 0
// heads the free list, the last slot heads the data list, so up to fourteen
// elements fit. One request is worked at a time. An insert runs check, pop,
// walk, link and emit, a delete check, walk, unlink, free and emit; the walk
// down the data list reads one link per cycle through the single read port of
// the link table. The result register lets the next request be accepted while
// a result still waits to be taken.
// top level: sll_ctrl and sll_dp, channels sll_req_if and sll_rsp_if, sll_pkg

module static_linked_list_engine_core import sll_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sll_req_if.sink   req,
	sll_rsp_if.source rsp
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	sll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	sll_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.command       (req.command),
		.position      (req.position),
		.value         (req.value),
		.status        (rsp.status),
		.slot          (rsp.slot),
		.removed_value (rsp.removed_value),
		.length        (rsp.length)
	);

`ifndef SYNTHESIS
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while busy");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.length <= MAX_ELEMS)
		else $error("length beyond table capacity");

	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_DONE |-> rsp.slot != FREE_HEAD && rsp.slot != DATA_HEAD)
		else $error("completed request reports a head slot");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_DONE |-> rsp.slot == '0 && rsp.removed_value == '0)
		else $error("failed request reports slot or value");
`endif

endmodule
